/* rtl/core/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the C source tokenizer: record layouts,
// token class codes, queue sizing and the keyword table.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Input item: one source byte or an end marker.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_item_t;

  // Result item as seen on the output port.
  typedef struct packed {
    logic [2:0]  token_class;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic [5:0]  keyword_index;
    logic [7:0]  single_char;
    logic        last_of_run;
  } out_item_t;

  // Token class codes.
  localparam logic [2:0] CLS_KEYWORD  = 3'd0;
  localparam logic [2:0] CLS_IDENT    = 3'd1;
  localparam logic [2:0] CLS_INT      = 3'd2;
  localparam logic [2:0] CLS_FLOAT    = 3'd3;
  localparam logic [2:0] CLS_CHAR     = 3'd4;
  localparam logic [2:0] CLS_STRING   = 3'd5;
  localparam logic [2:0] CLS_OP       = 3'd6;
  localparam logic [2:0] CLS_MISMATCH = 3'd7;

  // Length cap: min(TOKEN_LEN_LIMIT, 255).
  localparam int         TOKEN_LEN_LIMIT = 255;
  localparam logic [7:0] LEN_CAP = 8'((TOKEN_LEN_LIMIT > 255) ? 255 : TOKEN_LEN_LIMIT);

  // Token record between front and back. The back resolves keywords from
  // the packed first characters of a word token.
  typedef struct packed {
    logic [2:0]  cls;
    logic [31:0] start;
    logic [7:0]  length;
    logic [63:0] window;
    logic        kw_cand;
    logic [7:0]  single_char;
  } tok_rec_t;

  typedef struct packed {
    tok_rec_t rec;
    logic     last;
  } qent_t;

  // Front-to-queue write bundle: up to two records per transaction.
  typedef struct packed {
    logic [1:0] n;
    qent_t      e0;
    qent_t      e1;
  } q_wr_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Keyword table, characters packed right-aligned, first character highest.
  localparam int KW_COUNT = 34;
  localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
    64'h6175746f,          // auto
    64'h627265616b,        // break
    64'h63617365,          // case
    64'h63686172,          // char
    64'h636f6e7374,        // const
    64'h636f6e74696e7565,  // continue
    64'h64656661756c74,    // default
    64'h646f,              // do
    64'h646f75626c65,      // double
    64'h656c7365,          // else
    64'h656e756d,          // enum
    64'h65787465726e,      // extern
    64'h666c6f6174,        // float
    64'h666f72,            // for
    64'h676f746f,          // goto
    64'h6966,              // if
    64'h696e6c696e65,      // inline
    64'h696e74,            // int
    64'h6c6f6e67,          // long
    64'h7265676973746572,  // register
    64'h7265737472696374,  // restrict
    64'h72657475726e,      // return
    64'h73686f7274,        // short
    64'h7369676e6564,      // signed
    64'h73697a656f66,      // sizeof
    64'h737461746963,      // static
    64'h737472756374,      // struct
    64'h737769746368,      // switch
    64'h74797065646566,    // typedef
    64'h756e696f6e,        // union
    64'h756e7369676e6564,  // unsigned
    64'h766f6964,          // void
    64'h766f6c6174696c65,  // volatile
    64'h7768696c65         // while
  };

  typedef struct packed {
    logic       found;
    logic [5:0] idx;
  } kw_hit_t;

  // Parallel compare against all keywords. Word characters are nonzero, so
  // a packed match also implies a length match.
  function automatic kw_hit_t kw_lookup(input logic [63:0] w);
    kw_hit_t h;
    h = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (w == KW_WORDS[i]) begin
        h.found = 1'b1;
        h.idx   = 6'(i);
      end
    end
    return h;
  endfunction

endpackage

/* rtl/core/cst_front.sv */
// ----------------------------------------------------------------------------
// cst_front
// Lexer front end: per-byte mode update, up to two token records per
// transaction (the terminating byte is rescanned from idle).
// ----------------------------------------------------------------------------
module cst_front #(
  parameter int POSITION_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  cst_pkg::in_item_t item,
  output cst_pkg::q_wr_t   wr
);
  import cst_pkg::*;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_INT    = 4'd2;
  localparam logic [3:0] M_FLOAT  = 4'd3;
  localparam logic [3:0] M_CHAR1  = 4'd4;
  localparam logic [3:0] M_CHAR2  = 4'd5;
  localparam logic [3:0] M_STRING = 4'd6;
  localparam logic [3:0] M_SLASH  = 4'd7;
  localparam logic [3:0] M_LINE   = 4'd8;
  localparam logic [3:0] M_BLOCK  = 4'd9;
  localparam logic [3:0] M_STAR   = 4'd10;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  logic [3:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [7:0]               len_r, len_nxt;
  logic [63:0]              win_r, win_nxt;
  logic                     long_r, long_nxt;

  tok_rec_t   rec_a, rec_b;
  logic       a_v, b_v, redo;
  logic [7:0] c;

  function automatic logic is_space(input logic [7:0] x);
    return (x == 8'h20) || (x >= 8'h09 && x <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] x);
    return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= 8'h30 && x <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] x);
    logic r;
    case (x)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3E, 8'h3C, 8'h21, 8'h26, 8'h7C,
      8'h25, 8'h5E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C,
      8'h2E, 8'h3A: r = 1'b1;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < LEN_CAP) ? v + 8'd1 : v;
  endfunction

  function automatic logic [31:0] to_start(input logic [POSITION_BITS-1:0] p);
    logic [63:0] e;
    e = 64'(p);
    return e[31:0];
  endfunction

  function automatic tok_rec_t mk(input logic [2:0] cls,
                                  input logic [POSITION_BITS-1:0] st,
                                  input logic [7:0] len,
                                  input logic [63:0] w,
                                  input logic kwc,
                                  input logic [7:0] ch);
    tok_rec_t r;
    r.cls         = cls;
    r.start       = to_start(st);
    r.length      = len;
    r.window      = w;
    r.kw_cand     = kwc;
    r.single_char = ch;
    return r;
  endfunction

  assign c = item.source_byte;

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    win_nxt   = win_r;
    long_nxt  = long_r;
    rec_a     = '0;
    rec_b     = '0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    redo      = 1'b0;
    if (take) begin
      if (item.end_of_input) begin
        // flush pending token, position holds
        unique case (mode_r)
          M_IDENT: begin
            a_v   = 1'b1;
            rec_a = mk(CLS_IDENT, start_r, len_r, win_r, !long_r, 8'd0);
          end
          M_INT: begin
            a_v   = 1'b1;
            rec_a = mk(CLS_INT, start_r, len_r, '0, 1'b0, 8'd0);
          end
          M_FLOAT: begin
            a_v   = 1'b1;
            rec_a = mk(CLS_FLOAT, start_r, len_r, '0, 1'b0, 8'd0);
          end
          M_STRING: begin
            a_v   = 1'b1;
            rec_a = mk(CLS_STRING, start_r, sat_inc(len_r), '0, 1'b0, 8'd0);
          end
          M_SLASH: begin
            a_v   = 1'b1;
            rec_a = mk(CLS_OP, start_r, 8'd1, '0, 1'b0, CH_SLASH);
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
        len_nxt  = 8'd0;
        win_nxt  = '0;
        long_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
        unique case (mode_r)
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
              if (len_r < 8'd8) win_nxt = {win_r[55:0], c};
              else long_nxt = 1'b1;
              len_nxt = sat_inc(len_r);
            end else begin
              a_v   = 1'b1;
              rec_a = mk(CLS_IDENT, start_r, len_r, win_r, !long_r, 8'd0);
              redo  = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(c)) begin
              len_nxt = sat_inc(len_r);
            end else if (c == CH_DOT) begin
              len_nxt  = sat_inc(len_r);
              mode_nxt = M_FLOAT;
            end else begin
              a_v   = 1'b1;
              rec_a = mk(CLS_INT, start_r, len_r, '0, 1'b0, 8'd0);
              redo  = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(c)) begin
              len_nxt = sat_inc(len_r);
            end else begin
              a_v   = 1'b1;
              rec_a = mk(CLS_FLOAT, start_r, len_r, '0, 1'b0, 8'd0);
              redo  = 1'b1;
            end
          end
          M_CHAR1: begin
            len_nxt  = 8'd2;
            mode_nxt = M_CHAR2;
          end
          M_CHAR2: begin
            mode_nxt = M_IDLE;
            if (c == CH_QUOTE) begin
              a_v   = 1'b1;
              rec_a = mk(CLS_CHAR, start_r, 8'd3, '0, 1'b0, 8'd0);
            end else begin
              redo = 1'b1;  // broken char literal: drop it, rescan this byte
            end
          end
          M_STRING: begin
            len_nxt = sat_inc(len_r);
            if (c == CH_DQUOTE) begin
              a_v      = 1'b1;
              rec_a    = mk(CLS_STRING, start_r, sat_inc(len_r), '0, 1'b0, 8'd0);
              mode_nxt = M_IDLE;
            end
          end
          M_SLASH: begin
            if (c == CH_SLASH) begin
              mode_nxt = M_LINE;
            end else if (c == CH_STAR) begin
              mode_nxt = M_BLOCK;
            end else begin
              a_v   = 1'b1;
              rec_a = mk(CLS_OP, start_r, 8'd1, '0, 1'b0, CH_SLASH);
              redo  = 1'b1;
            end
          end
          M_LINE: begin
            if (c == CH_NL) mode_nxt = M_IDLE;
          end
          M_BLOCK: begin
            if (c == CH_STAR) mode_nxt = M_STAR;
          end
          M_STAR: begin
            if (c == CH_SLASH) mode_nxt = M_IDLE;
            else if (c != CH_STAR) mode_nxt = M_BLOCK;
          end
          default: redo = 1'b1;
        endcase

        // scan from idle: a fresh byte, or the byte that ended a token
        if (redo) begin
          mode_nxt = M_IDLE;
          if (is_space(c)) begin
            mode_nxt = M_IDLE;
          end else if (is_alpha(c) || c == CH_UNDER) begin
            mode_nxt  = M_IDENT;
            start_nxt = pos_r;
            len_nxt   = 8'd1;
            win_nxt   = {56'd0, c};
            long_nxt  = 1'b0;
          end else if (is_digit(c)) begin
            mode_nxt  = M_INT;
            start_nxt = pos_r;
            len_nxt   = 8'd1;
          end else if (c == CH_QUOTE) begin
            mode_nxt  = M_CHAR1;
            start_nxt = pos_r;
            len_nxt   = 8'd1;
          end else if (c == CH_DQUOTE) begin
            mode_nxt  = M_STRING;
            start_nxt = pos_r;
            len_nxt   = 8'd1;
          end else if (c == CH_SLASH) begin
            mode_nxt  = M_SLASH;
            start_nxt = pos_r;
            len_nxt   = 8'd1;
          end else if (is_op(c)) begin
            b_v   = 1'b1;
            rec_b = mk(CLS_OP, pos_r, 8'd1, '0, 1'b0, c);
          end else begin
            b_v   = 1'b1;
            rec_b = mk(CLS_MISMATCH, pos_r, 8'd1, '0, 1'b0, c);
          end
        end
      end
    end
  end

  // compact the pair; last flag on the final record of the transaction
  always_comb begin
    wr.n       = {1'b0, a_v} + {1'b0, b_v};
    wr.e0.rec  = a_v ? rec_a : rec_b;
    wr.e0.last = !(a_v && b_v);
    wr.e1.rec  = rec_b;
    wr.e1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= 8'd0;
      win_r   <= '0;
      long_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      win_r   <= win_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

/* rtl/core/cst_queue.sv */
// ----------------------------------------------------------------------------
// cst_queue
// Record queue between front and back: two writes, one read per cycle.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cst_pkg::q_wr_t  wr,
  output logic            full,
  output logic            rd_valid,
  output cst_pkg::qent_t  rd_entry,
  input  logic            rd_ready
);
  import cst_pkg::*;

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           rd_fire;

  // room for a worst-case pair of records
  assign full     = cnt_r > QCW'(QDEPTH - 2);
  assign rd_valid = cnt_r != '0;
  assign rd_entry = mem_r[rp_r];
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) mem_r[wp_r] <= wr.e0;
    if (wr.n == 2'd2) mem_r[QAW'(wp_r + QAW'(1))] <= wr.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QAW'(wr.n);
      rp_r  <= rp_r + QAW'(rd_fire);
      cnt_r <= cnt_r + QCW'(wr.n) - QCW'(rd_fire);
    end
  end

endmodule

/* rtl/core/cst_back.sv */
// ----------------------------------------------------------------------------
// cst_back
// Back end: keyword resolution and the output register.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_valid,
  input  cst_pkg::qent_t    rd_entry,
  output logic              rd_ready,
  output logic              empty,
  input  logic              pop,
  output cst_pkg::out_item_t out_item
);
  import cst_pkg::*;

  logic      valid_r;
  out_item_t data_r, data_nxt;
  kw_hit_t   hit;
  logic      is_kw;
  logic      load;

  assign hit   = kw_lookup(rd_entry.rec.window);
  assign is_kw = rd_entry.rec.kw_cand && hit.found;

  always_comb begin
    data_nxt.token_class   = is_kw ? CLS_KEYWORD : rd_entry.rec.cls;
    data_nxt.token_start   = rd_entry.rec.start;
    data_nxt.token_length  = rd_entry.rec.length;
    data_nxt.keyword_index = is_kw ? hit.idx : 6'd0;
    data_nxt.single_char   = rd_entry.rec.single_char;
    data_nxt.last_of_run   = rd_entry.last;
  end

  assign load     = rd_valid && (!valid_r || pop);
  assign rd_ready = load;
  assign empty    = !valid_r;
  assign out_item = data_r;

  always_ff @(posedge clk) begin
    if (load) data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

endmodule

/* rtl/core/c_source_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// c_source_tokenizer_unit
// Streaming C lexer: one source byte per input transaction, one token record
// per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive in_item and raise push; the
//   transaction completes on a clock edge with push high and full low. An
//   item with end_of_input set flushes the pending token; its byte is
//   ignored and the position counter does not advance.
//   Output side is a queue read port: while empty is low, out_item holds the
//   oldest record; it is taken on an edge with pop high. last_of_run marks
//   the final record produced by one input transaction (at most two).
//   Path: a record is written into the queue at the accepting edge and then
//   loaded into the output register once the queue holds it and the register
//   is empty or being popped; a second record from the same byte follows it.
//   Throughput: one byte per cycle while full is low, as the front end
//   updates its mode on every accepted byte. The back end drains one record
//   per cycle while the output register is empty or popped, so a byte that
//   yields two records outpaces it; a four-entry queue absorbs the burst, and
//   full rises when fewer than two entries are free. A stalled reader fills
//   the queue and then full holds off the writer; no record is dropped.
//   Reset (rst_n low, synchronous) empties the queue and output register,
//   returns the lexer to idle and clears the byte position.
// ----------------------------------------------------------------------------
module c_source_tokenizer_unit #(
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  cst_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output cst_pkg::out_item_t out_item
);
  import cst_pkg::*;

  logic   take;
  q_wr_t  q_wr;
  logic   q_rd_valid;
  qent_t  q_rd_entry;
  logic   q_rd_ready;

  // front only advances on an accepted transaction
  assign take = push && !full;

  cst_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_item),
    .wr    (q_wr)
  );

  cst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .full     (full),
    .rd_valid (q_rd_valid),
    .rd_entry (q_rd_entry),
    .rd_ready (q_rd_ready)
  );

  cst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (q_rd_valid),
    .rd_entry (q_rd_entry),
    .rd_ready (q_rd_ready),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
